### design/mic_pkg.sv
package mic_pkg;

    localparam int LANES = 4;
    localparam int EOI_BYTES = 4;
    localparam int ENTRY_BYTES = 4;
    localparam int ROW_W = 7;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DONE = 1'b1
    } back_state_t;

    // One classified transaction. Byte lane L of the window holds every byte whose
    // window offset is L modulo four; row 0 is the EOI word, row r is IRQ entry r-1.
    typedef struct packed {
        cmd_t                         cmd;
        logic                         fits;
        logic                         eoi_clear;
        logic                         raise_ok;
        logic [5:0]                   irq;
        logic [2:0]                   size;
        logic [1:0]                   rot;
        logic [LANES-1:0]             lane_en;
        logic [LANES-1:0][ROW_W-1:0]  lane_row;
        logic [LANES-1:0][7:0]        lane_byte;
    } mic_item_t;

endpackage

### design/mic_req_if.sv
interface mic_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic [5:0]  irq_id;

    modport source (
        output valid, command, address, access_size, write_data, irq_id,
        input  ready
    );
    modport sink (
        input  valid, command, address, access_size, write_data, irq_id,
        output ready
    );
endinterface

### design/mic_rsp_if.sv
interface mic_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] read_data;
    logic        irq_line_out;
    logic [7:0]  vector_out;

    modport source (
        output valid, ok, read_data, irq_line_out, vector_out,
        input  ready
    );
    modport sink (
        input  valid, ok, read_data, irq_line_out, vector_out,
        output ready
    );
endinterface

### design/mic_front.sv
module mic_front #(
    parameter int NUM_IRQS    = 64,
    parameter int WINDOW_BASE = 57344
) (
    input  logic                clk,
    input  logic                rst_n,
    mic_req_if.sink             request,
    output logic                item_valid,
    input  logic                item_ready,
    output mic_pkg::mic_item_t  item
);
    import mic_pkg::*;

    localparam logic [16:0] WINDOW_END = 17'(WINDOW_BASE + EOI_BYTES + ENTRY_BYTES * NUM_IRQS);

    mic_item_t   item_reg;
    mic_item_t   item_next;
    logic        valid_reg;
    logic        accept;
    logic [15:0] offset;
    logic        size_good;
    logic        fits;
    logic [1:0]  k;
    logic [8:0]  byte_pos;

    assign request.ready = !valid_reg || item_ready;
    assign accept = request.valid && request.ready;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb
    begin
        offset = request.address - 16'(WINDOW_BASE);
        size_good = (request.access_size != 3'd0) && (request.access_size <= 3'd4);
        fits = size_good && (request.address >= 16'(WINDOW_BASE))
               && (({1'b0, request.address} + 17'(request.access_size)) <= WINDOW_END);
        item_next.cmd = cmd_t'(request.command);
        item_next.fits = fits;
        item_next.eoi_clear = fits && (offset == 16'd0) && (request.write_data[7:0] == 8'd0);
        item_next.raise_ok = {26'd0, request.irq_id} < 32'(NUM_IRQS);
        item_next.irq = request.irq_id;
        item_next.size = request.access_size;
        item_next.rot = offset[1:0];
        for (int l = 0; l < LANES; l++)
        begin
            k = 2'(l) - offset[1:0];
            byte_pos = offset[8:0] + 9'(k);
            item_next.lane_en[l] = fits && ({1'b0, k} < request.access_size);
            item_next.lane_row[l] = byte_pos[8:2];
            item_next.lane_byte[l] = request.write_data[{k, 3'b000} +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end
endmodule

### design/mic_queue.sv
module mic_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mic_pkg::mic_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mic_pkg::mic_item_t  pop_item
);
    import mic_pkg::*;

    mic_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

### design/mic_back.sv
module mic_back #(
    parameter int NUM_IRQS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mic_pkg::mic_item_t  item,
    mic_rsp_if.source           response
);
    import mic_pkg::*;

    localparam int IDX_W = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;

    back_state_t           state_reg;
    back_state_t           state_next;
    mic_item_t             cur_reg;
    logic                  took_reg;
    logic [LANES-1:0][7:0] eoi_reg;
    logic [NUM_IRQS-1:0]   pending_reg;
    logic [NUM_IRQS-1:0]   enable_reg;
    logic                  in_service_reg;
    logic                  line_reg;
    logic [7:0]            vector_reg;
    logic                  out_valid_reg;
    logic                  ok_reg;
    logic [31:0]           rdata_reg;
    logic                  line_out_reg;
    logic [7:0]            vector_out_reg;

    logic                  issue;
    logic                  finish;
    logic [NUM_IRQS-1:0]   cand;
    logic [NUM_IRQS-1:0]   pend_tick;
    logic                  take;
    logic [IDX_W-1:0]      win;
    logic [LANES-1:0][7:0] lane_data;
    logic [31:0]           rdata;
    logic [7:0]            vector_new;
    logic                  ok;
    logic [1:0]            lane_sel;

    assign item_ready = (state_reg == ST_IDLE);
    assign issue = item_valid && item_ready;
    assign finish = (state_reg == ST_DONE) && (!out_valid_reg || response.ready);

    assign response.valid = out_valid_reg;
    assign response.ok = ok_reg;
    assign response.read_data = rdata_reg;
    assign response.irq_line_out = line_out_reg;
    assign response.vector_out = vector_out_reg;

    always_comb
    begin
        cand = pending_reg & enable_reg;
        take = !in_service_reg && (cand != '0);
        win = '0;
        for (int i = NUM_IRQS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                win = IDX_W'(i);
            end
        end
        pend_tick = cand;
        if (take)
        begin
            pend_tick[win] = 1'b0;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [7:0]          mem [NUM_IRQS];
        logic [NUM_IRQS-1:0] vld_reg;
        logic [7:0]          q_reg;
        logic                qv_reg;
        logic                q_eoi_reg;
        logic                wr;
        logic                rd;
        logic [IDX_W-1:0]    addr;
        logic [ROW_W-1:0]    row_m1;

        always_comb
        begin
            row_m1 = item.lane_row[l] - ROW_W'(1);
            wr = issue && (item.cmd == CMD_WRITE) && item.lane_en[l]
                 && (item.lane_row[l] != '0);
            rd = issue && (((item.cmd == CMD_READ) && item.lane_en[l])
                 || ((item.cmd == CMD_TICK) && (l == 0)));
            addr = (item.cmd == CMD_TICK) ? win : IDX_W'(row_m1);
        end

        always_ff @(posedge clk)
        begin
            if (wr)
            begin
                mem[addr] <= item.lane_byte[l];
            end
            if (rd)
            begin
                q_reg <= mem[addr];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= '0;
                qv_reg <= 1'b0;
                q_eoi_reg <= 1'b0;
            end
            else
            begin
                if (wr)
                begin
                    vld_reg[addr] <= 1'b1;
                end
                if (rd)
                begin
                    qv_reg <= vld_reg[addr];
                    q_eoi_reg <= (item.cmd != CMD_TICK) && (item.lane_row[l] == '0);
                end
            end
        end

        assign lane_data[l] = q_eoi_reg ? eoi_reg[l] : (qv_reg ? q_reg : 8'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rdata = '0;
        for (int k = 0; k < LANES; k++)
        begin
            lane_sel = cur_reg.rot + 2'(k);
            if ((cur_reg.cmd == CMD_READ) && cur_reg.fits && (3'(k) < cur_reg.size))
            begin
                rdata[8*k +: 8] = lane_data[lane_sel];
            end
        end
        vector_new = ((cur_reg.cmd == CMD_TICK) && took_reg) ? lane_data[0] : vector_reg;
        ok = ((cur_reg.cmd == CMD_WRITE) || (cur_reg.cmd == CMD_READ)) ? cur_reg.fits : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            took_reg <= 1'b0;
            eoi_reg <= '0;
            pending_reg <= '0;
            enable_reg <= '0;
            in_service_reg <= 1'b0;
            line_reg <= 1'b0;
            vector_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (issue)
            begin
                took_reg <= take;
                case (item.cmd)
                    CMD_WRITE:
                    begin
                        for (int l = 0; l < LANES; l++)
                        begin
                            if (item.lane_en[l] && (item.lane_row[l] == '0))
                            begin
                                eoi_reg[l] <= item.lane_byte[l];
                            end
                            if (item.lane_en[l] && (item.lane_row[l] != '0) && (l == 2))
                            begin
                                enable_reg[IDX_W'(item.lane_row[l] - ROW_W'(1))]
                                    <= item.lane_byte[l][0];
                            end
                        end
                        if (item.eoi_clear)
                        begin
                            in_service_reg <= 1'b0;
                        end
                    end
                    CMD_READ:
                    begin
                    end
                    CMD_RAISE:
                    begin
                        if (item.raise_ok)
                        begin
                            pending_reg[IDX_W'(item.irq)] <= 1'b1;
                        end
                    end
                    CMD_TICK:
                    begin
                        pending_reg <= pend_tick;
                        if (take)
                        begin
                            in_service_reg <= 1'b1;
                            line_reg <= 1'b1;
                            eoi_reg <= 32'h0000_0001;
                        end
                        else if (!in_service_reg)
                        begin
                            line_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (finish)
            begin
                vector_reg <= vector_new;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cur_reg <= item;
        end
        if (finish)
        begin
            ok_reg <= ok;
            rdata_reg <= rdata;
            line_out_reg <= line_reg;
            vector_out_reg <= vector_new;
        end
    end
endmodule

### design/mmio_interrupt_controller.sv
// The execution unit takes one transaction at a time: it reads the entry memory, then
// forms the result in its response registers, and takes no new transaction until that
// result is loaded, which waits while an earlier response has not been taken.
// Reset (rst_n, asynchronous, active low) clears the EOI word, pending, enable,
// in-service, line, vector and per-byte valid bits; unwritten entry bytes read as zero.
module mmio_interrupt_controller #(
    parameter int NUM_IRQS    = 64,
    parameter int WINDOW_BASE = 57344
) (
    input  logic       clk,
    input  logic       rst_n,
    mic_req_if.sink    request,
    mic_rsp_if.source  response
);
    import mic_pkg::*;

    logic      front_valid;
    logic      front_ready;
    mic_item_t front_item;
    logic      back_valid;
    logic      back_ready;
    mic_item_t back_item;

    mic_front #(
        .NUM_IRQS    (NUM_IRQS),
        .WINDOW_BASE (WINDOW_BASE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    mic_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    mic_back #(
        .NUM_IRQS (NUM_IRQS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .response   (response)
    );
endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mic_pkg::*;

    localparam int NUM_IRQS    = 64;
    localparam int WINDOW_BASE = 57344;
    localparam int WIN_LEN     = EOI_BYTES + ENTRY_BYTES * NUM_IRQS;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_TXNS = 2000;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] address;
        logic [2:0]  access_size;
        logic [31:0] write_data;
        logic [5:0]  irq_id;
    } mic_request_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic        irq_line;
        logic [7:0]  vector;
    } mic_response_t;

    // Tracks the register window, pending bits and service state, and holds the
    // responses that accepted requests are due to produce, oldest first.
    class irq_ctrl_model;
        logic [7:0]    window_mem [WIN_LEN];
        bit            pending [NUM_IRQS];
        bit            in_service;
        bit            line_on;
        logic [7:0]    vector;
        mic_response_t expected_rsp [$];
        int unsigned   mismatches;

        function new();
            foreach (window_mem[i]) window_mem[i] = 8'h00;
            foreach (pending[i]) pending[i] = 1'b0;
            in_service  = 1'b0;
            line_on     = 1'b0;
            vector      = 8'h00;
            mismatches  = 0;
        endfunction

        function bit access_fits(logic [15:0] addr, logic [2:0] size);
            int unsigned a;
            a = addr;
            if (size == 3'd0 || size > 3'd4)
            begin
                return 1'b0;
            end
            if (a < WINDOW_BASE)
            begin
                return 1'b0;
            end
            return (a + size) <= (WINDOW_BASE + WIN_LEN);
        endfunction

        function void run_tick();
            int unsigned base;
            if (!in_service)
            begin
                line_on = 1'b0;
            end
            for (int i = 0; i < NUM_IRQS; i++)
            begin
                base = EOI_BYTES + ENTRY_BYTES * i;
                if (!window_mem[base + 2][0])
                begin
                    pending[i] = 1'b0;
                end
                else if (pending[i] && !in_service)
                begin
                    in_service    = 1'b1;
                    pending[i]    = 1'b0;
                    line_on       = 1'b1;
                    vector        = window_mem[base];
                    window_mem[0] = 8'h01;
                    window_mem[1] = 8'h00;
                    window_mem[2] = 8'h00;
                    window_mem[3] = 8'h00;
                end
            end
        endfunction

        function void note_request(mic_request_t t);
            mic_response_t r;
            int unsigned   off;
            r = '0;
            case (t.command)
                CMD_WRITE:
                begin
                    if (access_fits(t.address, t.access_size))
                    begin
                        off = t.address - WINDOW_BASE;
                        for (int k = 0; k < t.access_size; k++)
                        begin
                            window_mem[off + k] = t.write_data[8 * k +: 8];
                        end
                        if (off == 0 && t.write_data[7:0] == 8'h00)
                        begin
                            in_service = 1'b0;
                        end
                        r.ok = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (access_fits(t.address, t.access_size))
                    begin
                        off = t.address - WINDOW_BASE;
                        for (int k = 0; k < t.access_size; k++)
                        begin
                            r.read_data[8 * k +: 8] = window_mem[off + k];
                        end
                        r.ok = 1'b1;
                    end
                end
                CMD_RAISE:
                begin
                    if (t.irq_id < NUM_IRQS)
                    begin
                        pending[t.irq_id] = 1'b1;
                    end
                    r.ok = 1'b1;
                end
                default:
                begin
                    run_tick();
                    r.ok = 1'b1;
                end
            endcase
            r.irq_line = line_on;
            r.vector   = vector;
            expected_rsp.push_back(r);
        endfunction

        function void check_response(mic_response_t got);
            mic_response_t want;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: response with none outstanding: ok=%0b data=%08h line=%0b vec=%02h",
                             $realtime, got.ok, got.read_data, got.irq_line, got.vector);
                end
                return;
            end
            want = expected_rsp.pop_front();
            if (got.ok !== want.ok || got.read_data !== want.read_data ||
                got.irq_line !== want.irq_line || got.vector !== want.vector)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch: expected ok=%0b data=%08h line=%0b vec=%02h",
                             $realtime, want.ok, want.read_data, want.irq_line, want.vector);
                    $display("%0t:           actual   ok=%0b data=%08h line=%0b vec=%02h",
                             $realtime, got.ok, got.read_data, got.irq_line, got.vector);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mic_req_if request_ch ();
    mic_rsp_if response_ch ();

    mmio_interrupt_controller #(
        .NUM_IRQS    (NUM_IRQS),
        .WINDOW_BASE (WINDOW_BASE)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    irq_ctrl_model window_model = new();

    int          burst_left  = 0;
    int          quiet_cycles = 0;
    logic [15:0] stall_mask;
    logic [3:0]  stall_phase = 4'd0;
    mic_request_t  seen_req;
    mic_response_t seen_rsp;

    always #10 clk = ~clk;

    function automatic mic_request_t make_req(cmd_t c, logic [15:0] a, logic [2:0] s,
                                              logic [31:0] d, logic [5:0] n);
        mic_request_t t;
        t.command     = c;
        t.address     = a;
        t.access_size = s;
        t.write_data  = d;
        t.irq_id      = n;
        return t;
    endfunction

    function automatic logic [2:0] pick_size();
        if ($urandom_range(0, 9) == 0)
        begin
            return 3'($urandom_range(0, 7));
        end
        return 3'($urandom_range(1, 4));
    endfunction

    function automatic mic_request_t random_request();
        mic_request_t t;
        int unsigned  pick;
        int unsigned  sub;
        t.command     = CMD_TICK;
        t.address     = 16'($urandom_range(0, 65535));
        t.access_size = pick_size();
        t.write_data  = $urandom;
        t.irq_id      = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        if (pick < 30)
        begin
            t.command = CMD_WRITE;
            if (sub < 3)
            begin
                t.address = 16'(WINDOW_BASE);
                t.access_size = 3'($urandom_range(1, 4));
                if (sub < 2)
                begin
                    t.write_data[7:0] = 8'h00;
                end
            end
            else if (sub < 8)
            begin
                t.address = 16'(WINDOW_BASE + EOI_BYTES + ENTRY_BYTES * $urandom_range(0, 63)
                                + $urandom_range(0, 3));
            end
        end
        else if (pick < 50)
        begin
            t.command = CMD_READ;
            if (sub < 8)
            begin
                t.address = 16'(WINDOW_BASE + $urandom_range(0, WIN_LEN + 3));
            end
        end
        else if (pick < 75)
        begin
            t.command = CMD_RAISE;
        end
        return t;
    endfunction

    task automatic issue(input mic_request_t t);
        if (burst_left == 0)
        begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        request_ch.valid       <= 1'b1;
        request_ch.command     <= t.command;
        request_ch.address     <= t.address;
        request_ch.access_size <= t.access_size;
        request_ch.write_data  <= t.write_data;
        request_ch.irq_id      <= t.irq_id;
        @(posedge clk);
        while (!request_ch.ready) @(posedge clk);
    endtask

    initial
    begin
        response_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_phase == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hFFFF;
                    1: stall_mask = 16'($urandom);
                    2: stall_mask = 16'($urandom & $urandom);
                    default: stall_mask = 16'hF0F0;
                endcase
                stall_mask[$urandom_range(0, 15)] = 1'b1;
            end
            response_ch.ready <= stall_mask[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (request_ch.valid && request_ch.ready)
            begin
                seen_req = make_req(cmd_t'(request_ch.command), request_ch.address,
                                    request_ch.access_size, request_ch.write_data,
                                    request_ch.irq_id);
                window_model.note_request(seen_req);
                quiet_cycles = 0;
            end
            if (response_ch.valid && response_ch.ready)
            begin
                seen_rsp.ok        = response_ch.ok;
                seen_rsp.read_data = response_ch.read_data;
                seen_rsp.irq_line  = response_ch.irq_line_out;
                seen_rsp.vector    = response_ch.vector_out;
                window_model.check_response(seen_rsp);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                  <= 1'b0;
        request_ch.valid       <= 1'b0;
        request_ch.command     <= CMD_WRITE;
        request_ch.address     <= 16'h0000;
        request_ch.access_size <= 3'd0;
        request_ch.write_data  <= 32'h0;
        request_ch.irq_id      <= 6'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Program two entries, raise three IRQs and take the lowest enabled one.
        issue(make_req(CMD_READ,  16'hE000, 3'd4, 32'h0,          6'd0));
        issue(make_req(CMD_WRITE, 16'hE018, 3'd4, 32'h0001_3CA5,  6'd0));
        issue(make_req(CMD_WRITE, 16'hE00C, 3'd4, 32'hFFFF_7742,  6'd0));
        issue(make_req(CMD_RAISE, 16'h0000, 3'd0, 32'h0,          6'd5));
        issue(make_req(CMD_RAISE, 16'hFFFF, 3'd7, 32'hFFFF_FFFF,  6'd2));
        issue(make_req(CMD_RAISE, 16'h0000, 3'd0, 32'h0,          6'd63));
        issue(make_req(CMD_TICK,  16'h0000, 3'd0, 32'h0,          6'd0));
        issue(make_req(CMD_READ,  16'hE000, 3'd4, 32'h0,          6'd0));
        // A write that overlaps the EOI word without starting on it must not end service.
        issue(make_req(CMD_WRITE, 16'hE001, 3'd2, 32'h0,          6'd0));
        issue(make_req(CMD_TICK,  16'h0000, 3'd0, 32'h0,          6'd0));
        issue(make_req(CMD_WRITE, 16'hE000, 3'd1, 32'hFFFF_FF00,  6'd0));
        issue(make_req(CMD_TICK,  16'h0000, 3'd0, 32'h0,          6'd0));
        issue(make_req(CMD_WRITE, 16'hE000, 3'd4, 32'hFFFF_FF00,  6'd0));
        issue(make_req(CMD_TICK,  16'h0000, 3'd0, 32'h0,          6'd0));
        // Refused sizes and addresses outside or straddling the window, and a read of its last byte.
        issue(make_req(CMD_WRITE, 16'hE000, 3'd0, 32'h0,          6'd0));
        issue(make_req(CMD_READ,  16'hE004, 3'd5, 32'h0,          6'd0));
        issue(make_req(CMD_WRITE, 16'hE004, 3'd7, 32'hFFFF_FFFF,  6'd0));
        issue(make_req(CMD_WRITE, 16'hDFFF, 3'd2, 32'hFFFF_FFFF,  6'd0));
        issue(make_req(CMD_READ,  16'hFFFF, 3'd4, 32'h0,          6'd0));
        issue(make_req(CMD_WRITE, 16'hE101, 3'd4, 32'hFFFF_FFFF,  6'd0));
        issue(make_req(CMD_READ,  16'hE103, 3'd1, 32'h0,          6'd0));
        // The last entry of the window is programmed, raised and taken.
        issue(make_req(CMD_WRITE, 16'hE100, 3'd4, 32'hFFFF_FFFF,  6'd0));
        issue(make_req(CMD_RAISE, 16'h0000, 3'd0, 32'h0,          6'd63));
        issue(make_req(CMD_TICK,  16'h0000, 3'd0, 32'h0,          6'd0));
        issue(make_req(CMD_READ,  16'hE0FF, 3'd4, 32'h0,          6'd0));
        issue(make_req(CMD_WRITE, 16'hE000, 3'd1, 32'h0,          6'd0));

        for (int i = 0; i < RANDOM_TXNS; i++)
        begin
            issue(random_request());
        end
        request_ch.valid <= 1'b0;
        @(posedge clk);

        while (window_model.expected_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (window_model.mismatches == 0 && window_model.expected_rsp.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
